[rtl/ssc_pkg.sv]
`default_nettype none

package ssc_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned MaxN  = 4096;
  localparam int unsigned IdxW  = $clog2(MaxN);
  localparam int unsigned SizeW = 12;
  localparam int unsigned ValW  = 30;
  localparam int unsigned MulW  = ValW + 2;

  // Prime modulus, Fermat exponent and Barrett constant floor(2^(2*ValW) / P).
  localparam logic [ValW-1:0] ModP      = 30'd998244353;
  localparam logic [ValW-1:0] FermatExp = ModP - 30'd2;
  localparam logic [63:0]     BarrettMu = (64'd1 << (2 * ValW)) / 64'(ModP);

  // Operand selection of the shared modular multiplier.
  typedef enum logic [2:0] {
    MUL_FACT = 3'd0,
    MUL_ACC  = 3'd1,
    MUL_SQ   = 3'd2,
    MUL_BIN1 = 3'd3,
    MUL_BIN2 = 3'd4,
    MUL_TERM = 3'd5
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    init_tab;
    logic    load_item;
    logic    fm_read;
    logic    fm_load;
    logic    term_read;
    logic    inv_read_mi;
    logic    mul_start;
    mul_op_e mul_op;
    logic    inv_write;
    logic    next_term;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_bit0;
    logic last_k;
    logic last_i;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/surjection_count_mod_prime_top.sv]
`default_nettype none

// Counts the surjections from a set of set_size_i elements onto a set of
// target_size_i elements, modulo 998244353, by inclusion-exclusion.
// Input channel: in_valid_i / in_stall_o with set_size_i and target_size_i;
// an item is taken at an edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with count_o, one item per input.
// After reset the block fills its factorial and inverse-factorial memories
// (k = 1 .. 4095, one Fermat inversion each), holding in_stall_o high
// until the tables are full. Each item's time then grows with the target
// size m (at most 4095) and with the bit length and the number of set bits
// of the set size; it is set by the single shared modular multiplier and
// the square-and-multiply loop. One item is worked on at a time.
// A finished count sits in the output register; while the receiver stalls
// the block still accepts and computes the next item, and only waits before
// loading the next count until the held one has been taken.
module surjection_count_mod_prime_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ssc_pkg::SizeW-1:0] set_size_i,
  input  logic [ssc_pkg::SizeW-1:0] target_size_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ssc_pkg::ValW-1:0]  count_o
);

  import ssc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  ssc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Tables, multiplier and working registers.
  ssc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .set_size_i    (set_size_i),
    .target_size_i (target_size_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .count_o       (count_o)
  );

endmodule

`default_nettype wire

[rtl/ssc_ram.sv]
`default_nettype none

module ssc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/ssc_mulmod.sv]
`default_nettype none

module ssc_mulmod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ssc_pkg::ValW-1:0] a_i,
  input  logic [ssc_pkg::ValW-1:0] b_i,
  output logic                     done_o,
  output logic [ssc_pkg::ValW-1:0] res_o
);

  import ssc_pkg::*;

  // Phases after the product has been taken.
  localparam logic [1:0] PhEst  = 2'd1;
  localparam logic [1:0] PhFold = 2'd2;
  localparam logic [1:0] PhFix  = 2'd3;

  localparam logic [MulW-1:0] OneModP = MulW'(ModP);
  localparam logic [MulW-1:0] TwoModP = {1'b0, ModP, 1'b0};

  logic              busy_q;
  logic [1:0]        ph_q;
  logic              done_q;
  logic [2*ValW-1:0] x_q;
  logic [63:0]       prod_q;
  logic [ValW-1:0]   res_q;
  logic [MulW-1:0]   mul_a;
  logic [MulW-1:0]   mul_b;
  logic [63:0]       prod_w;
  logic [MulW-1:0]   rem_w;

  // One shared multiplier: a*b, then the Barrett quotient estimate, then q*P.
  always_comb begin
    mul_a = MulW'(a_i);
    mul_b = MulW'(b_i);
    if (busy_q && ph_q == PhEst) begin
      mul_a = MulW'(x_q[2*ValW-1:ValW-1]);
      mul_b = BarrettMu[MulW-1:0];
    end else if (busy_q && ph_q == PhFold) begin
      mul_a = MulW'(prod_q[2*ValW+1:ValW+1]);
      mul_b = OneModP;
    end
  end

  assign prod_w = 64'(mul_a) * 64'(mul_b);

  // The remainder estimate lies below 3P; it fits in the low word.
  assign rem_w = x_q[MulW-1:0] - prod_q[MulW-1:0];

  // Phase sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PhEst;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          ph_q   <= PhEst;
        end
      end else begin
        case (ph_q)
          PhEst:  ph_q <= PhFold;
          PhFold: ph_q <= PhFix;
          PhFix: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  // Product, intermediate and final remainder.
  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      x_q <= prod_w[2*ValW-1:0];
    end
    if (busy_q && (ph_q == PhEst || ph_q == PhFold)) begin
      prod_q <= prod_w;
    end
    if (busy_q && ph_q == PhFix) begin
      if (rem_w >= TwoModP) begin
        res_q <= ValW'(rem_w - TwoModP);
      end else if (rem_w >= OneModP) begin
        res_q <= ValW'(rem_w - OneModP);
      end else begin
        res_q <= rem_w[ValW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("Multiplication started while the unit was busy.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (res_q < ModP))
    else $error("Modular product not fully reduced.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("Completion signalled while the unit was still busy.");
`endif

endmodule

`default_nettype wire

[rtl/ssc_dp.sv]
`default_nettype none

module ssc_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssc_pkg::cmd_t             cmd_i,
  output ssc_pkg::stat_t            stat_o,
  input  logic [ssc_pkg::SizeW-1:0] set_size_i,
  input  logic [ssc_pkg::SizeW-1:0] target_size_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ssc_pkg::ValW-1:0]  count_o
);

  import ssc_pkg::*;

  logic [IdxW-1:0]  k_q;
  logic [IdxW-1:0]  i_q;
  logic [IdxW-1:0]  m_q;
  logic [SizeW-1:0] n_q;
  logic [ValW-1:0]  fact_q;
  logic [ValW-1:0]  acc_q;
  logic [ValW-1:0]  base_q;
  logic [ValW-1:0]  exp_q;
  logic [ValW-1:0]  inva_q;
  logic [ValW-1:0]  binom_q;
  logic [ValW-1:0]  sum_q;
  logic [ValW-1:0]  count_q;
  mul_op_e          op_q;
  logic             out_valid_q;

  logic [IdxW-1:0]  m_sat;
  logic [ValW-1:0]  mul_a;
  logic [ValW-1:0]  mul_b;
  logic [ValW-1:0]  mul_res;
  logic             mul_done;
  logic [ValW:0]    sum_add;
  logic [ValW:0]    sum_sub;
  logic [ValW-1:0]  sum_next;

  logic             fact_we;
  logic [IdxW-1:0]  fact_waddr;
  logic [ValW-1:0]  fact_wdata;
  logic [ValW-1:0]  fact_rdata;
  logic             inv_we;
  logic [IdxW-1:0]  inv_waddr;
  logic [ValW-1:0]  inv_wdata;
  logic             inv_re;
  logic [IdxW-1:0]  inv_raddr;
  logic [ValW-1:0]  inv_rdata;

  // Target sizes beyond the tables use the last entry.
  assign m_sat = (32'(target_size_i) > MaxN - 1) ? IdxW'(MaxN - 1) : IdxW'(target_size_i);

  // Multiplier operands, sampled in the cycle the multiplication starts.
  always_comb begin
    case (cmd_i.mul_op)
      MUL_FACT: begin mul_a = ValW'(k_q); mul_b = fact_q;    end
      MUL_ACC:  begin mul_a = acc_q;      mul_b = base_q;    end
      MUL_SQ:   begin mul_a = base_q;     mul_b = base_q;    end
      MUL_BIN1: begin mul_a = inva_q;     mul_b = inv_rdata; end
      MUL_BIN2: begin mul_a = binom_q;    mul_b = fact_q;    end
      MUL_TERM: begin mul_a = binom_q;    mul_b = acc_q;     end
      default:  begin mul_a = '0;         mul_b = '0;        end
    endcase
  end

  ssc_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // Signed accumulation of the inclusion-exclusion terms.
  always_comb begin
    sum_add = {1'b0, sum_q} + {1'b0, mul_res};
    sum_sub = {1'b0, sum_q} + {1'b0, ModP} - {1'b0, mul_res};
    if (m_q[0] ^ i_q[0]) begin
      sum_next = (sum_q >= mul_res) ? (sum_q - mul_res) : sum_sub[ValW-1:0];
    end else begin
      sum_next = (sum_add >= {1'b0, ModP}) ? ValW'(sum_add - {1'b0, ModP})
                                           : sum_add[ValW-1:0];
    end
  end

  // Table write and read ports.
  assign fact_we    = cmd_i.init_tab || (mul_done && op_q == MUL_FACT);
  assign fact_waddr = cmd_i.init_tab ? '0 : k_q;
  assign fact_wdata = cmd_i.init_tab ? ValW'(1) : mul_res;
  assign inv_we     = cmd_i.init_tab || cmd_i.inv_write;
  assign inv_waddr  = cmd_i.init_tab ? '0 : k_q;
  assign inv_wdata  = cmd_i.init_tab ? ValW'(1) : acc_q;
  assign inv_re     = cmd_i.term_read || cmd_i.inv_read_mi;
  assign inv_raddr  = cmd_i.term_read ? i_q : (m_q - i_q);

  ssc_ram #(
    .Width (ValW),
    .Depth (MaxN)
  ) u_fact_ram (
    .clk_i   (clk_i),
    .we_i    (fact_we),
    .waddr_i (fact_waddr),
    .wdata_i (fact_wdata),
    .re_i    (cmd_i.fm_read),
    .raddr_i (m_q),
    .rdata_o (fact_rdata)
  );

  ssc_ram #(
    .Width (ValW),
    .Depth (MaxN)
  ) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (inv_waddr),
    .wdata_i (inv_wdata),
    .re_i    (inv_re),
    .raddr_i (inv_raddr),
    .rdata_o (inv_rdata)
  );

  // Counters, latched operation and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      i_q         <= '0;
      op_q        <= MUL_FACT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_tab) begin
        k_q <= IdxW'(1);
      end else if (cmd_i.inv_write) begin
        k_q <= k_q + IdxW'(1);
      end
      if (cmd_i.load_item) begin
        i_q <= '0;
      end else if (cmd_i.next_term) begin
        i_q <= i_q + IdxW'(1);
      end
      if (cmd_i.mul_start) begin
        op_q <= cmd_i.mul_op;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working values; each product goes where its operation says.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_tab) begin
      fact_q <= ValW'(1);
    end
    if (cmd_i.fm_load) begin
      fact_q <= fact_rdata;
    end
    if (cmd_i.load_item) begin
      n_q   <= set_size_i;
      m_q   <= m_sat;
      sum_q <= '0;
    end
    if (cmd_i.term_read) begin
      base_q <= ValW'(i_q);
      acc_q  <= ValW'(1);
      exp_q  <= ValW'(n_q);
    end
    if (cmd_i.inv_read_mi) begin
      inva_q <= inv_rdata;
    end
    if (cmd_i.out_load) begin
      count_q <= sum_q;
    end
    if (mul_done) begin
      case (op_q)
        MUL_FACT: begin
          fact_q <= mul_res;
          base_q <= mul_res;
          acc_q  <= ValW'(1);
          exp_q  <= FermatExp;
        end
        MUL_ACC: acc_q <= mul_res;
        MUL_SQ: begin
          base_q <= mul_res;
          exp_q  <= exp_q >> 1;
        end
        MUL_BIN1: binom_q <= mul_res;
        MUL_BIN2: binom_q <= mul_res;
        MUL_TERM: sum_q   <= sum_next;
        default: ;
      endcase
    end
  end

  // Status towards the controller.
  assign stat_o.mul_done = mul_done;
  assign stat_o.exp_zero = (exp_q == '0);
  assign stat_o.exp_bit0 = exp_q[0];
  assign stat_o.last_k   = (k_q == IdxW'(MaxN - 1));
  assign stat_o.last_i   = (i_q == m_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_q |-> (count_q < ModP))
    else $error("Result item is not reduced modulo the prime.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(count_q)))
    else $error("Stalled result item changed or was dropped.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("Result register loaded while a stalled item was held.");
`endif

endmodule

`default_nettype wire

[rtl/ssc_ctrl.sv]
`default_nettype none

module ssc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ssc_pkg::stat_t stat_i,
  output ssc_pkg::cmd_t  cmd_o
);

  import ssc_pkg::*;

  typedef enum logic [14:0] {
    ST_INIT     = 15'h0001,
    ST_FACT     = 15'h0002,
    ST_POW_CHK  = 15'h0004,
    ST_POW_ACC  = 15'h0008,
    ST_POW_SQ   = 15'h0010,
    ST_INV_WR   = 15'h0020,
    ST_IDLE     = 15'h0040,
    ST_FM_RD    = 15'h0080,
    ST_FM_LD    = 15'h0100,
    ST_TERM_RD  = 15'h0200,
    ST_TERM_RD2 = 15'h0400,
    ST_BIN1     = 15'h0800,
    ST_BIN2     = 15'h1000,
    ST_TERM     = 15'h2000,
    ST_DONE     = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic   ready_q, ready_d;
  logic   mul_busy;

  // Next state and commands. A multiplying state starts the unit once and
  // waits for its completion.
  always_comb begin
    state_d  = state_q;
    ready_d  = ready_q;
    cmd_o    = '0;
    mul_busy = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_tab = 1'b1;
        state_d        = ST_FACT;
      end
      ST_FACT: begin
        mul_busy     = 1'b1;
        cmd_o.mul_op = MUL_FACT;
        if (stat_i.mul_done) state_d = ST_POW_CHK;
      end
      ST_POW_CHK: begin
        if (stat_i.exp_zero) begin
          state_d = ready_q ? ST_TERM : ST_INV_WR;
        end else if (stat_i.exp_bit0) begin
          state_d = ST_POW_ACC;
        end else begin
          state_d = ST_POW_SQ;
        end
      end
      ST_POW_ACC: begin
        mul_busy     = 1'b1;
        cmd_o.mul_op = MUL_ACC;
        if (stat_i.mul_done) state_d = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        mul_busy     = 1'b1;
        cmd_o.mul_op = MUL_SQ;
        if (stat_i.mul_done) state_d = ST_POW_CHK;
      end
      ST_INV_WR: begin
        cmd_o.inv_write = 1'b1;
        if (stat_i.last_k) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FACT;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_FM_RD;
        end
      end
      ST_FM_RD: begin
        cmd_o.fm_read = 1'b1;
        state_d       = ST_FM_LD;
      end
      ST_FM_LD: begin
        cmd_o.fm_load = 1'b1;
        state_d       = ST_TERM_RD;
      end
      ST_TERM_RD: begin
        cmd_o.term_read = 1'b1;
        state_d         = ST_TERM_RD2;
      end
      ST_TERM_RD2: begin
        cmd_o.inv_read_mi = 1'b1;
        state_d           = ST_BIN1;
      end
      ST_BIN1: begin
        mul_busy     = 1'b1;
        cmd_o.mul_op = MUL_BIN1;
        if (stat_i.mul_done) state_d = ST_BIN2;
      end
      ST_BIN2: begin
        mul_busy     = 1'b1;
        cmd_o.mul_op = MUL_BIN2;
        if (stat_i.mul_done) state_d = ST_POW_CHK;
      end
      ST_TERM: begin
        mul_busy     = 1'b1;
        cmd_o.mul_op = MUL_TERM;
        if (stat_i.mul_done) begin
          if (stat_i.last_i) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.next_term = 1'b1;
            state_d         = ST_TERM_RD;
          end
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
    cmd_o.mul_start = mul_busy && !issued_q;
    issued_d        = mul_busy && !stat_i.mul_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      issued_q <= 1'b0;
      ready_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ready_q  <= ready_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_stall_o |-> ready_q)
    else $error("Item accepted before the tables were filled.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) stat_i.mul_done |-> issued_q)
    else $error("Multiplier completion without an outstanding request.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.mul_start |=> !cmd_o.mul_start)
    else $error("Multiplier started in two consecutive cycles.");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;
  import ssc_pkg::*;

  // Clock, reset and the ports of the block.
  logic             clk;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [SizeW-1:0] set_size_i    = '0;
  logic [SizeW-1:0] target_size_i = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [ValW-1:0]  count_o;

  // Counts still to come, oldest first.
  logic [ValW-1:0] count_expect_q[$];

  // Factorials and their inverses modulo the prime, as the block holds them.
  logic [ValW-1:0] fact_tab[MaxN];
  logic [ValW-1:0] inv_fact_tab[MaxN];

  int unsigned error_count = 0;
  longint      cycle_count = 0;
  // The limit grows with every item sent; it starts with room for the table fill.
  longint      cycle_limit = 64'd5_610_000;
  // While set, neither side idles.
  bit          no_idle     = 1'b0;
  // A long hold-off requested of the receiver, in cycles.
  int unsigned hold_req    = 0;

  surjection_count_mod_prime_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .set_size_i    (set_size_i),
    .target_size_i (target_size_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .count_o       (count_o)
  );

  // Free-running clock with a period of ten units.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that overruns the limit has hung.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > cycle_limit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Modular arithmetic over the prime.
  function automatic logic [ValW-1:0] mod_mul(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return ValW'(prod % 64'(ModP));
  endfunction

  function automatic logic [ValW-1:0] mod_add(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [ValW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ModP}) s = s - {1'b0, ModP};
    return s[ValW-1:0];
  endfunction

  function automatic logic [ValW-1:0] mod_sub(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
    logic [ValW:0] s;
    s = {1'b0, a} + {1'b0, ModP} - {1'b0, b};
    if (s >= {1'b0, ModP}) s = s - {1'b0, ModP};
    return s[ValW-1:0];
  endfunction

  // Square-and-multiply; zero to the zeroth power comes out as one.
  function automatic logic [ValW-1:0] mod_pow(input logic [ValW-1:0] base,
                                              input logic [ValW-1:0] expo);
    logic [ValW-1:0] acc;
    logic [ValW-1:0] sq;
    logic [ValW-1:0] e;
    acc = ValW'(1);
    sq  = base % ModP;
    e   = expo;
    while (e != '0) begin
      if (e[0]) acc = mod_mul(acc, sq);
      e  = e >> 1;
      sq = mod_mul(sq, sq);
    end
    return acc;
  endfunction

  // Fills both tables; each inverse is a Fermat power of the factorial.
  function automatic void build_factorial_tables();
    fact_tab[0]     = ValW'(1);
    inv_fact_tab[0] = ValW'(1);
    for (int unsigned k = 1; k < MaxN; k++) begin
      fact_tab[k]     = mod_mul(ValW'(k), fact_tab[k-1]);
      inv_fact_tab[k] = mod_pow(fact_tab[k], FermatExp);
    end
  endfunction

  function automatic logic [ValW-1:0] choose(input int unsigned top, input int unsigned pick);
    if (pick > top || top >= MaxN) return '0;
    return mod_mul(mod_mul(inv_fact_tab[top-pick], inv_fact_tab[pick]), fact_tab[top]);
  endfunction

  // Inclusion-exclusion over i = 0..m of (-1)^(m-i) * C(m,i) * i^n.
  function automatic logic [ValW-1:0] surjections(input logic [SizeW-1:0] n,
                                                  input logic [SizeW-1:0] m);
    int unsigned     top;
    logic [ValW-1:0] total;
    logic [ValW-1:0] term;
    top = m;
    if (top > MaxN - 1) top = MaxN - 1;
    total = '0;
    for (int unsigned i = 0; i <= top; i++) begin
      term = mod_mul(choose(top, i), mod_pow(ValW'(i), ValW'(n)));
      if (((top - i) & 1) != 0) total = mod_sub(total, term);
      else total = mod_add(total, term);
    end
    return total;
  endfunction

  // Rough cycles the block spends on one item, from the target size and the bits of the set size.
  function automatic longint item_cycles(input logic [SizeW-1:0] n, input logic [SizeW-1:0] m);
    longint bits;
    longint ones;
    bits = $clog2(int'(n) + 1);
    ones = $countones(n);
    return 3 + (longint'(m) + 1) * (18 + 6 * bits + 5 * ones);
  endfunction

  // Offers one item, with random idle cycles first, and returns at the edge
  // that takes it. Valid is left high so that the next item may follow at once.
  task automatic send_item(input logic [SizeW-1:0] n, input logic [SizeW-1:0] m);
    logic stalled;
    count_expect_q.push_back(surjections(n, m));
    cycle_limit += 4 * item_cycles(n, m) + 2000;
    while (!no_idle && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i    <= 1'b1;
    set_size_i    <= n;
    target_size_i <= m;
    do begin
      @(negedge clk);
      stalled = in_stall_o;
      @(posedge clk);
    end while (stalled);
  endtask

  // Receiver: random stalls, a quiet stretch and, on request, a long hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 24);
      end
    end
  end

  // Result checker: the handshake is sampled mid-cycle and acted on at the edge.
  initial begin
    logic            take;
    logic [ValW-1:0] seen;
    logic [ValW-1:0] want;
    forever begin
      @(negedge clk);
      take = rst_ni && out_valid_o && !out_stall_i;
      seen = count_o;
      @(posedge clk);
      if (take) begin
        if (count_expect_q.size() == 0) begin
          $error("count: no item pending, got %0d", seen);
          error_count++;
        end else begin
          want = count_expect_q.pop_front();
          if (seen !== want) begin
            $error("count: expected %0d, got %0d", want, seen);
            error_count++;
          end
        end
      end
    end
  end

  // Small sizes with known answers and the special cases.
  task automatic test_small_cases();
    send_item(12'd0, 12'd0);     // zero to the zeroth power
    send_item(12'd1, 12'd0);
    send_item(12'd0, 12'd1);
    send_item(12'd1, 12'd1);
    send_item(12'd3, 12'd2);
    send_item(12'd5, 12'd3);
    send_item(12'd2, 12'd5);     // target larger than source
    send_item(12'd12, 12'd12);
    send_item(12'd13, 12'd12);
    send_item(12'd4095, 12'd0);
    send_item(12'd4095, 12'd1);
    send_item(12'd4095, 12'd2);
    send_item(12'd2730, 12'd7);
    send_item(12'd1365, 12'd9);
  endtask

  // Wide target sizes: the top bit alone, then every bit set.
  task automatic test_wide_fields();
    send_item(12'd0, 12'd2048);
    send_item(12'd0, 12'd4095);
    send_item(12'd4095, 12'd4095);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and stalls its input.
  task automatic test_backpressure();
    no_idle      = 1'b1;
    hold_req     = 20000;
    cycle_limit += 4 * 20000;
    for (int k = 0; k < 6; k++) begin
      send_item(SizeW'($urandom_range(15)), SizeW'($urandom_range(4)));
    end
    no_idle = 1'b0;
  endtask

  // Random items, mostly with small targets; the first stretch runs without idling.
  task automatic test_random_items();
    logic [SizeW-1:0] n;
    logic [SizeW-1:0] m;
    int unsigned      pick;
    for (int k = 0; k < 77; k++) begin
      no_idle = (k < 25);
      pick = $urandom_range(99);
      if (pick < 70) m = SizeW'($urandom_range(12));
      else if (pick < 95) m = SizeW'($urandom_range(64, 13));
      else m = SizeW'($urandom_range(300, 65));
      if ($urandom_range(1) == 0) n = SizeW'($urandom_range(int'(m) + 8));
      else n = SizeW'($urandom_range(4095));
      send_item(n, m);
    end
    no_idle = 1'b0;
  endtask

  // Main sequence: reset, the tests in turn, drain, verdict.
  initial begin
    build_factorial_tables();
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_small_cases();
    test_wide_fields();
    test_backpressure();
    test_random_items();

    in_valid_i <= 1'b0;
    while (count_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/ssc_pkg.sv
rtl/ssc_ram.sv
rtl/ssc_mulmod.sv
rtl/ssc_dp.sv
rtl/ssc_ctrl.sv
rtl/surjection_count_mod_prime_top.sv
sim/tb_top.sv
